FILE: rtl/shal_pkg.sv
// shal_pkg: shared types, constants and helper functions of the segregated heap allocator
// used by shal_engine and segregated_heap_allocator_core; no dependencies
package shal_pkg;

    // heap geometry
    localparam int unsigned HEAP_BYTES  = 1048576;
    localparam int unsigned NUM_CLASSES = 16;
    localparam int unsigned STORE_WORDS = HEAP_BYTES / 4;
    localparam int unsigned WORD_AW     = $clog2(STORE_WORDS);
    localparam int unsigned WALK_LIMIT  = HEAP_BYTES / 16;
    localparam int unsigned STEP_W      = $clog2(WALK_LIMIT + 1);

    typedef logic [31:0] word_t;
    typedef logic [3:0]  cls_t;

    localparam word_t HEAD_MARK   = 32'd8;
    localparam word_t ADDR_MASK   = 32'h000F_FFFF;
    localparam word_t SIZE_MASK   = 32'h001F_FFFF;
    localparam word_t TAG_MASK    = 32'hFFFF_FFF8;
    localparam word_t MIN_PAYLOAD = 32'd88;
    localparam word_t MIN_BLOCK   = 32'd16;
    localparam cls_t  LAST_CLASS  = 4'd15;
    localparam cls_t  RESET_CLASS = 4'd12;
    localparam logic [20:0] CHUNK_RESET = 21'd4096;
    localparam logic [20:0] BREAK_RESET = 21'd4184;

    // kind codes of an input item
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // word indexes of the initial heap image
    localparam logic [WORD_AW-1:0] IW_PRO_HDR = WORD_AW'(19);
    localparam logic [WORD_AW-1:0] IW_PRO_FTR = WORD_AW'(20);
    localparam logic [WORD_AW-1:0] IW_BLK_HDR = WORD_AW'(21);
    localparam logic [WORD_AW-1:0] IW_BLK_PRV = WORD_AW'(22);
    localparam logic [WORD_AW-1:0] IW_BLK_FTR = WORD_AW'(1044);
    localparam logic [WORD_AW-1:0] IW_EPI     = WORD_AW'(1045);

    typedef struct packed {
        logic        kind;
        logic [20:0] request_bytes;
        logic [19:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [19:0] granted_addr;
        logic        is_null;
        logic [20:0] granted_bytes;
    } res_t;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_DONE,
        ST_F_CHK, ST_F_SZ, ST_F_NX,
        ST_G_START, ST_G_FT, ST_G_EPI, ST_G_MRG,
        ST_C_START, ST_C_RD, ST_C_W1, ST_C_W2, ST_C_W3, ST_C_W4,
        ST_R_CHK, ST_R_HDR, ST_R_FTR, ST_R_W2, ST_R_MRG,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M_UL, ST_M_PS, ST_M_NS, ST_M_TOT,
        ST_M_W1, ST_M_W2,
        ST_U0, ST_U1, ST_U2, ST_U3, ST_U4,
        ST_I0, ST_I1, ST_I2, ST_I3
    } state_t;

    // upper size bound of each class but the last
    function automatic word_t class_bound(cls_t c);
        word_t b;
        unique case (c)
            4'd0:    b = 32'd12;
            4'd1:    b = 32'd24;
            4'd2:    b = 32'd32;
            4'd3:    b = 32'd64;
            4'd4:    b = 32'd80;
            4'd5:    b = 32'd96;
            4'd6:    b = 32'd120;
            4'd7:    b = 32'd240;
            4'd8:    b = 32'd360;
            4'd9:    b = 32'd720;
            4'd10:   b = 32'd1440;
            4'd11:   b = 32'd2880;
            4'd12:   b = 32'd5760;
            4'd13:   b = 32'd11520;
            4'd14:   b = 32'd23040;
            default: b = 32'd0;
        endcase
        return b;
    endfunction

    // smallest class whose bound holds the size
    function automatic cls_t class_of(word_t sz);
        cls_t r;
        r = LAST_CLASS;
        for (int i = 14; i >= 0; i--) begin
            if (sz <= class_bound(cls_t'(i))) begin
                r = cls_t'(i);
            end
        end
        return r;
    endfunction

    function automatic word_t head_mark(cls_t c);
        return HEAD_MARK + {26'd0, c, 2'b00};
    endfunction

    // heap word contents after reset
    function automatic word_t init_word(logic [WORD_AW-1:0] idx);
        word_t w;
        unique case (idx)
            IW_PRO_HDR: w = 32'd9;
            IW_PRO_FTR: w = 32'd9;
            IW_BLK_HDR: w = 32'd4096;
            IW_BLK_PRV: w = head_mark(RESET_CLASS);
            IW_BLK_FTR: w = 32'd4096;
            IW_EPI:     w = 32'd1;
            default:    w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/segregated_heap_allocator_core.sv
// An allocate walks the class lists for a first fit, one list entry at a time, and grows the
// heap when the walk finds none; a zero-size allocate goes straight to the result.
// Throughput: one item at a time, set by the single-port heap store; the result register lets
// the next item in. Reset: synchronous, active low; then a pass over all 262144 heap words
// rewrites the heap image, no item taken meanwhile (config is).
module segregated_heap_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: extend_chunk_bytes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_bytes [20:0], block_addr [40:21], zeros
    input  logic [0:0]  s_tuser,   // kind [0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // granted_addr [19:0], granted_bytes [40:20], zeros
    output logic [0:0]  m_tuser    // is_null [0]
);

    logic [20:0]    chunk_reg;
    logic           m_valid_reg;
    shal_pkg::res_t m_res_reg;

    shal_pkg::req_t eng_req;
    shal_pkg::res_t eng_res;
    logic           eng_req_ready;
    logic           eng_res_valid;
    logic           eng_res_ready;

    assign eng_req.kind          = s_tuser[0];
    assign eng_req.request_bytes = s_tdata[20:0];
    assign eng_req.block_addr    = s_tdata[40:21];

    assign eng_res_ready = !m_valid_reg || m_tready;

    shal_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req       (eng_req),
        .req_ready (eng_req_ready),
        .res_valid (eng_res_valid),
        .res       (eng_res),
        .res_ready (eng_res_ready),
        .chunk     (chunk_reg)
    );

    assign s_tready  = eng_req_ready;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= shal_pkg::CHUNK_RESET;
        end else if (cfg_valid) begin
            chunk_reg <= cfg_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_res_valid && eng_res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_valid && eng_res_ready) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {7'd0, m_res_reg.granted_bytes, m_res_reg.granted_addr};
    assign m_tuser[0] = m_res_reg.is_null;

endmodule

FILE: rtl/shal_ram.sv
// shal_ram: single-port synchronous RAM with registered read data
// generic, no package dependencies
module shal_ram #(
    parameter int unsigned AW = 18,
    parameter int unsigned DW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    // write or read one word a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/shal_engine.sv
// shal_engine: request sequencer with the heap word store, class heads and heap break
// depends on shal_pkg and shal_ram
module shal_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    input  shal_pkg::req_t  req,
    output logic            req_ready,
    output logic            res_valid,
    output shal_pkg::res_t  res,
    input  logic            res_ready,
    input  logic [20:0]     chunk
);

    shal_pkg::state_t state_reg, state_next;
    shal_pkg::state_t sub_ret_reg, sub_ret_next;
    shal_pkg::state_t mrg_ret_reg, mrg_ret_next;

    shal_pkg::word_t asize_reg, asize_next;
    shal_pkg::word_t bp_reg, bp_next;
    shal_pkg::word_t got_reg, got_next;
    shal_pkg::word_t csize_reg, csize_next;
    shal_pkg::word_t hdr_reg, hdr_next;
    shal_pkg::word_t cur_reg, cur_next;
    shal_pkg::word_t sa_reg, sa_next;
    shal_pkg::word_t prev_reg, prev_next;
    shal_pkg::word_t next_reg, next_next;
    shal_pkg::word_t pb_reg, pb_next;
    shal_pkg::word_t nb_reg, nb_next;
    shal_pkg::word_t msize_reg, msize_next;
    shal_pkg::word_t ps_reg, ps_next;
    shal_pkg::word_t ns_reg, ns_next;
    shal_pkg::cls_t  cls_reg, cls_next;
    shal_pkg::cls_t  sc_reg, sc_next;
    logic [shal_pkg::STEP_W-1:0]  steps_reg, steps_next;
    logic [1:0]                   mph_reg, mph_next;
    logic                         pfree_reg, pfree_next;
    logic                         nfree_reg, nfree_next;
    logic                         null_reg, null_next;
    logic [shal_pkg::WORD_AW-1:0] clr_reg, clr_next;
    logic [20:0]                  brk_reg, brk_next;
    shal_pkg::word_t heads_reg [shal_pkg::NUM_CLASSES];
    shal_pkg::word_t heads_next [shal_pkg::NUM_CLASSES];

    // store port
    logic                         mem_we;
    shal_pkg::word_t              mem_a;
    shal_pkg::word_t              mem_wd;
    shal_pkg::word_t              mem_rd;
    logic [shal_pkg::WORD_AW-1:0] mem_idx;

    assign mem_idx = mem_a[shal_pkg::WORD_AW+1:2];

    shal_ram #(
        .AW (shal_pkg::WORD_AW),
        .DW (32)
    ) u_heap (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_idx),
        .wdata (mem_wd),
        .rdata (mem_rd)
    );

    // request decode
    shal_pkg::word_t req_bytes;
    shal_pkg::word_t req_asize;
    shal_pkg::cls_t  req_cls;

    assign req_bytes = {11'd0, req.request_bytes};
    assign req_asize = (req_bytes <= 32'd8) ? 32'd16 : (((req_bytes + 32'd15) >> 3) << 3);
    assign req_cls   = shal_pkg::class_of(req_asize);

    // heap growth amount
    shal_pkg::cls_t  g_cls;
    shal_pkg::word_t g_bound;
    shal_pkg::word_t g_ext;
    shal_pkg::word_t g_sz;
    logic            g_fits;

    assign g_cls   = shal_pkg::class_of(asize_reg);
    assign g_bound = shal_pkg::class_bound(g_cls);
    assign g_ext   = (g_cls == shal_pkg::LAST_CLASS) ? asize_reg :
                     ((g_bound > {11'd0, chunk}) ? g_bound : {11'd0, chunk});
    assign g_sz    = (((g_ext >> 2) + 32'd1) >> 1) << 3;
    assign g_fits  = ({12'd0, brk_reg} + {1'b0, g_sz}) <= 33'(shal_pkg::HEAP_BYTES);

    // misc datapath terms
    shal_pkg::word_t rd_tag;
    shal_pkg::word_t rd_cls_mark;
    shal_pkg::cls_t  rd_cls;
    shal_pkg::word_t c_rem;
    logic            c_split;
    shal_pkg::word_t f_sz;
    shal_pkg::word_t brk_w;
    logic            m_both;
    logic            m_ul_done;
    shal_pkg::word_t m_target;
    shal_pkg::word_t m_hdr_a;
    shal_pkg::word_t m_ftr_a;
    logic            m_ftr_first;

    assign rd_tag      = mem_rd & shal_pkg::TAG_MASK;
    assign rd_cls      = shal_pkg::class_of(rd_tag);
    assign rd_cls_mark = shal_pkg::head_mark(sc_reg);
    assign c_rem       = csize_reg - asize_reg;
    assign c_split     = c_rem >= shal_pkg::MIN_BLOCK;
    assign f_sz        = hdr_reg & shal_pkg::TAG_MASK;
    assign brk_w       = {11'd0, brk_reg};
    assign m_both      = pfree_reg && nfree_reg;
    assign m_ul_done   = (mph_reg == 2'd3) || ((mph_reg == 2'd2) && !m_both);
    assign m_target    = (mph_reg == 2'd0) ? (pfree_reg ? pb_reg : nb_reg) :
                         ((mph_reg == 2'd1) ? bp_reg : nb_reg);
    assign m_hdr_a     = (pfree_reg ? pb_reg : bp_reg) - 32'd4;
    assign m_ftr_a     = nb_reg + ns_reg - 32'd8;
    assign m_ftr_first = pfree_reg && !nfree_reg;

    // handshake and result
    assign req_ready = (state_reg == shal_pkg::ST_IDLE);
    assign res_valid = (state_reg == shal_pkg::ST_DONE);
    assign res.granted_addr  = null_reg ? 20'd0 : bp_reg[19:0];
    assign res.is_null       = null_reg;
    assign res.granted_bytes = null_reg ? 21'd0 : got_reg[20:0];

    // control and heap registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shal_pkg::ST_CLEAR;
            clr_reg   <= '0;
            brk_reg   <= shal_pkg::BREAK_RESET;
            for (int i = 0; i < shal_pkg::NUM_CLASSES; i++) begin
                heads_reg[i] <= (shal_pkg::cls_t'(i) == shal_pkg::RESET_CLASS) ?
                                shal_pkg::MIN_PAYLOAD : 32'd0;
            end
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            brk_reg   <= brk_next;
            for (int i = 0; i < shal_pkg::NUM_CLASSES; i++) begin
                heads_reg[i] <= heads_next[i];
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        sub_ret_reg <= sub_ret_next;
        mrg_ret_reg <= mrg_ret_next;
        asize_reg   <= asize_next;
        bp_reg      <= bp_next;
        got_reg     <= got_next;
        csize_reg   <= csize_next;
        hdr_reg     <= hdr_next;
        cur_reg     <= cur_next;
        sa_reg      <= sa_next;
        prev_reg    <= prev_next;
        next_reg    <= next_next;
        pb_reg      <= pb_next;
        nb_reg      <= nb_next;
        msize_reg   <= msize_next;
        ps_reg      <= ps_next;
        ns_reg      <= ns_next;
        cls_reg     <= cls_next;
        sc_reg      <= sc_next;
        steps_reg   <= steps_next;
        mph_reg     <= mph_next;
        pfree_reg   <= pfree_next;
        nfree_reg   <= nfree_next;
        null_reg    <= null_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        sub_ret_next = sub_ret_reg;
        mrg_ret_next = mrg_ret_reg;
        asize_next   = asize_reg;
        bp_next      = bp_reg;
        got_next     = got_reg;
        csize_next   = csize_reg;
        hdr_next     = hdr_reg;
        cur_next     = cur_reg;
        sa_next      = sa_reg;
        prev_next    = prev_reg;
        next_next    = next_reg;
        pb_next      = pb_reg;
        nb_next      = nb_reg;
        msize_next   = msize_reg;
        ps_next      = ps_reg;
        ns_next      = ns_reg;
        cls_next     = cls_reg;
        sc_next      = sc_reg;
        steps_next   = steps_reg;
        mph_next     = mph_reg;
        pfree_next   = pfree_reg;
        nfree_next   = nfree_reg;
        null_next    = null_reg;
        clr_next     = clr_reg;
        brk_next     = brk_reg;
        for (int i = 0; i < shal_pkg::NUM_CLASSES; i++) begin
            heads_next[i] = heads_reg[i];
        end
        mem_we = 1'b0;
        mem_a  = 32'd0;
        mem_wd = 32'd0;

        unique case (state_reg)
            // write the initial image over the whole store
            shal_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_a    = {{(30-shal_pkg::WORD_AW){1'b0}}, clr_reg, 2'b00};
                mem_wd   = shal_pkg::init_word(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = shal_pkg::ST_IDLE;
                end
            end

            shal_pkg::ST_IDLE: begin
                if (req_valid) begin
                    null_next = 1'b1;
                    bp_next   = {12'd0, req.block_addr};
                    if (req.kind == shal_pkg::KIND_ALLOC) begin
                        asize_next = req_asize;
                        cls_next   = req_cls;
                        cur_next   = heads_reg[req_cls];
                        steps_next = '0;
                        state_next = (req_bytes == 32'd0) ? shal_pkg::ST_DONE :
                                                            shal_pkg::ST_F_CHK;
                    end else begin
                        state_next = shal_pkg::ST_R_CHK;
                    end
                end
            end

            shal_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = shal_pkg::ST_IDLE;
                end
            end

            // first-fit walk over the lists
            shal_pkg::ST_F_CHK: begin
                if (cur_reg == 32'd0) begin
                    if (cls_reg == shal_pkg::LAST_CLASS) begin
                        state_next = shal_pkg::ST_G_START;
                    end else begin
                        cls_next = cls_reg + 1'b1;
                        cur_next = heads_reg[cls_reg + 1'b1];
                    end
                end else if (steps_reg >= shal_pkg::STEP_W'(shal_pkg::WALK_LIMIT)) begin
                    state_next = shal_pkg::ST_G_START;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    mem_a      = cur_reg - 32'd4;
                    state_next = shal_pkg::ST_F_SZ;
                end
            end

            shal_pkg::ST_F_SZ: begin
                if (rd_tag >= asize_reg) begin
                    bp_next    = cur_reg;
                    state_next = shal_pkg::ST_C_START;
                end else begin
                    mem_a      = cur_reg + 32'd4;
                    state_next = shal_pkg::ST_F_NX;
                end
            end

            shal_pkg::ST_F_NX: begin
                cur_next   = mem_rd & shal_pkg::ADDR_MASK;
                state_next = shal_pkg::ST_F_CHK;
            end

            // heap growth
            shal_pkg::ST_G_START: begin
                if (!g_fits) begin
                    state_next = shal_pkg::ST_DONE;
                end else begin
                    bp_next    = brk_w;
                    csize_next = g_sz;
                    mem_we     = 1'b1;
                    mem_a      = brk_w - 32'd4;
                    mem_wd     = g_sz;
                    state_next = shal_pkg::ST_G_FT;
                end
            end

            shal_pkg::ST_G_FT: begin
                mem_we     = 1'b1;
                mem_a      = bp_reg + csize_reg - 32'd8;
                mem_wd     = csize_reg;
                state_next = shal_pkg::ST_G_EPI;
            end

            shal_pkg::ST_G_EPI: begin
                mem_we       = 1'b1;
                mem_a        = bp_reg + csize_reg - 32'd4;
                mem_wd       = 32'd1;
                brk_next     = 21'(bp_reg + csize_reg);
                sa_next      = bp_reg;
                sub_ret_next = shal_pkg::ST_G_MRG;
                state_next   = shal_pkg::ST_I0;
            end

            shal_pkg::ST_G_MRG: begin
                mrg_ret_next = shal_pkg::ST_C_START;
                state_next   = shal_pkg::ST_M0;
            end

            // carve the chosen block
            shal_pkg::ST_C_START: begin
                mem_a      = bp_reg - 32'd4;
                state_next = shal_pkg::ST_C_RD;
            end

            shal_pkg::ST_C_RD: begin
                csize_next   = rd_tag;
                sa_next      = bp_reg;
                sub_ret_next = shal_pkg::ST_C_W1;
                state_next   = shal_pkg::ST_U0;
            end

            shal_pkg::ST_C_W1: begin
                null_next  = 1'b0;
                got_next   = c_split ? asize_reg : csize_reg;
                mem_we     = 1'b1;
                mem_a      = bp_reg - 32'd4;
                mem_wd     = (c_split ? asize_reg : csize_reg) | 32'd1;
                state_next = shal_pkg::ST_C_W2;
            end

            shal_pkg::ST_C_W2: begin
                mem_we     = 1'b1;
                mem_a      = bp_reg + got_reg - 32'd8;
                mem_wd     = got_reg | 32'd1;
                state_next = c_split ? shal_pkg::ST_C_W3 : shal_pkg::ST_DONE;
            end

            shal_pkg::ST_C_W3: begin
                mem_we     = 1'b1;
                mem_a      = bp_reg + asize_reg - 32'd4;
                mem_wd     = c_rem;
                state_next = shal_pkg::ST_C_W4;
            end

            shal_pkg::ST_C_W4: begin
                mem_we       = 1'b1;
                mem_a        = bp_reg + asize_reg + c_rem - 32'd8;
                mem_wd       = c_rem;
                sa_next      = bp_reg + asize_reg;
                sub_ret_next = shal_pkg::ST_DONE;
                state_next   = shal_pkg::ST_I0;
            end

            // free request: validate tags, then release
            shal_pkg::ST_R_CHK: begin
                if (bp_reg == 32'd0 || bp_reg[2:0] != 3'd0 ||
                    bp_reg < shal_pkg::MIN_PAYLOAD || bp_reg >= brk_w) begin
                    state_next = shal_pkg::ST_DONE;
                end else begin
                    mem_a      = bp_reg - 32'd4;
                    state_next = shal_pkg::ST_R_HDR;
                end
            end

            shal_pkg::ST_R_HDR: begin
                hdr_next = mem_rd;
                if (!mem_rd[0] || rd_tag < shal_pkg::MIN_BLOCK ||
                    ({1'b0, bp_reg} + {1'b0, rd_tag}) > {1'b0, brk_w}) begin
                    state_next = shal_pkg::ST_DONE;
                end else begin
                    mem_a      = bp_reg + rd_tag - 32'd8;
                    state_next = shal_pkg::ST_R_FTR;
                end
            end

            shal_pkg::ST_R_FTR: begin
                if (mem_rd != hdr_reg) begin
                    state_next = shal_pkg::ST_DONE;
                end else begin
                    mem_we     = 1'b1;
                    mem_a      = bp_reg - 32'd4;
                    mem_wd     = f_sz;
                    state_next = shal_pkg::ST_R_W2;
                end
            end

            shal_pkg::ST_R_W2: begin
                mem_we       = 1'b1;
                mem_a        = bp_reg + f_sz - 32'd8;
                mem_wd       = f_sz;
                sa_next      = bp_reg;
                sub_ret_next = shal_pkg::ST_R_MRG;
                state_next   = shal_pkg::ST_I0;
            end

            shal_pkg::ST_R_MRG: begin
                mrg_ret_next = shal_pkg::ST_DONE;
                state_next   = shal_pkg::ST_M0;
            end

            // coalesce bp with free neighbors
            shal_pkg::ST_M0: begin
                mem_a      = bp_reg - 32'd8;
                state_next = shal_pkg::ST_M1;
            end

            shal_pkg::ST_M1: begin
                pb_next    = bp_reg - rd_tag;
                pfree_next = !mem_rd[0];
                mem_a      = bp_reg - 32'd4;
                state_next = shal_pkg::ST_M2;
            end

            shal_pkg::ST_M2: begin
                msize_next = rd_tag;
                mem_a      = bp_reg + rd_tag - 32'd4;
                state_next = shal_pkg::ST_M3;
            end

            shal_pkg::ST_M3: begin
                nfree_next = !mem_rd[0];
                nb_next    = bp_reg + msize_reg;
                mph_next   = 2'd0;
                if (!pfree_reg && mem_rd[0]) begin
                    state_next = mrg_ret_reg;
                end else begin
                    state_next = shal_pkg::ST_M_UL;
                end
            end

            shal_pkg::ST_M_UL: begin
                if (m_ul_done) begin
                    state_next = shal_pkg::ST_M_PS;
                end else begin
                    sa_next      = m_target;
                    mph_next     = mph_reg + 1'b1;
                    sub_ret_next = shal_pkg::ST_M_UL;
                    state_next   = shal_pkg::ST_U0;
                end
            end

            shal_pkg::ST_M_PS: begin
                mem_a      = pb_reg - 32'd4;
                state_next = shal_pkg::ST_M_NS;
            end

            shal_pkg::ST_M_NS: begin
                ps_next    = pfree_reg ? rd_tag : 32'd0;
                mem_a      = nb_reg - 32'd4;
                state_next = shal_pkg::ST_M_TOT;
            end

            shal_pkg::ST_M_TOT: begin
                ns_next    = nfree_reg ? rd_tag : 32'd0;
                msize_next = msize_reg + ps_reg + (nfree_reg ? rd_tag : 32'd0);
                state_next = shal_pkg::ST_M_W1;
            end

            shal_pkg::ST_M_W1: begin
                mem_we     = 1'b1;
                mem_a      = m_ftr_first ? m_ftr_a : m_hdr_a;
                mem_wd     = msize_reg;
                state_next = shal_pkg::ST_M_W2;
            end

            shal_pkg::ST_M_W2: begin
                mem_we       = 1'b1;
                mem_a        = m_ftr_first ? m_hdr_a : m_ftr_a;
                mem_wd       = msize_reg;
                bp_next      = pfree_reg ? pb_reg : bp_reg;
                sa_next      = pfree_reg ? pb_reg : bp_reg;
                sub_ret_next = mrg_ret_reg;
                state_next   = shal_pkg::ST_I0;
            end

            // unlink sa from its list
            shal_pkg::ST_U0: begin
                mem_a      = sa_reg - 32'd4;
                state_next = shal_pkg::ST_U1;
            end

            shal_pkg::ST_U1: begin
                sc_next    = rd_cls;
                mem_a      = sa_reg;
                state_next = shal_pkg::ST_U2;
            end

            shal_pkg::ST_U2: begin
                prev_next  = mem_rd;
                mem_a      = sa_reg + 32'd4;
                state_next = shal_pkg::ST_U3;
            end

            shal_pkg::ST_U3: begin
                next_next = mem_rd;
                if (prev_reg == rd_cls_mark) begin
                    heads_next[sc_reg] = mem_rd & shal_pkg::ADDR_MASK;
                end else begin
                    mem_we = 1'b1;
                    mem_a  = prev_reg + 32'd4;
                    mem_wd = mem_rd;
                end
                state_next = shal_pkg::ST_U4;
            end

            shal_pkg::ST_U4: begin
                if (next_reg != 32'd0) begin
                    mem_we = 1'b1;
                    mem_a  = next_reg;
                    mem_wd = prev_reg;
                end
                state_next = sub_ret_reg;
            end

            // push sa at the head of its list
            shal_pkg::ST_I0: begin
                mem_a      = sa_reg - 32'd4;
                state_next = shal_pkg::ST_I1;
            end

            shal_pkg::ST_I1: begin
                next_next          = heads_reg[rd_cls];
                heads_next[rd_cls] = sa_reg;
                mem_we             = 1'b1;
                mem_a              = sa_reg;
                mem_wd             = shal_pkg::head_mark(rd_cls);
                state_next         = shal_pkg::ST_I2;
            end

            shal_pkg::ST_I2: begin
                mem_we     = 1'b1;
                mem_a      = sa_reg + 32'd4;
                mem_wd     = next_reg;
                state_next = shal_pkg::ST_I3;
            end

            shal_pkg::ST_I3: begin
                if (next_reg != 32'd0) begin
                    mem_we = 1'b1;
                    mem_a  = next_reg;
                    mem_wd = sa_reg;
                end
                state_next = sub_ret_reg;
            end

            default: begin
                state_next = shal_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for segregated_heap_allocator_core
// carries its own heap predictor; depends on shal_pkg and the core RTL
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP_SIZE = 1048576;
    localparam int unsigned WORDS     = HEAP_SIZE / 4;
    localparam int unsigned MARK_BASE = 8;
    localparam int unsigned AMASK     = 32'h000F_FFFF;
    localparam int unsigned SMASK     = 32'h001F_FFFF;
    localparam int unsigned SEARCH_MAX = HEAP_SIZE / 16;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned BOUND [15] = '{12, 24, 32, 64, 80, 96, 120, 240, 360, 720,
                                           1440, 2880, 5760, 11520, 23040};

    typedef struct {
        int unsigned addr;
        bit          nul;
        int unsigned bytes;
    } grant_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [20:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    segregated_heap_allocator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor state
    int unsigned heap_img [WORDS];
    int unsigned list_head [16];
    int unsigned brk;
    int unsigned chunk;

    grant_t      pending_grants [$];
    int unsigned live_blocks [$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int unsigned heap_rd(int unsigned a);
        return heap_img[(a >> 2) % WORDS];
    endfunction

    function automatic void heap_wr(int unsigned a, int unsigned v);
        heap_img[(a >> 2) % WORDS] = v;
    endfunction

    function automatic int unsigned tag_size(int unsigned bp);
        return heap_rd(bp - 4) & ~32'd7;
    endfunction

    function automatic int unsigned size_class(int unsigned sz);
        for (int i = 0; i < 15; i++) begin
            if (sz <= BOUND[i]) return i;
        end
        return 15;
    endfunction

    function automatic void list_push(int unsigned bp);
        int unsigned c;
        int unsigned old;
        c = size_class(tag_size(bp));
        old = list_head[c];
        list_head[c] = bp;
        heap_wr(bp, MARK_BASE + 4 * c);
        heap_wr(bp + 4, old);
        if (old != 0) heap_wr(old, bp);
    endfunction

    function automatic void list_drop(int unsigned bp);
        int unsigned c;
        int unsigned prv;
        int unsigned nxt;
        c = size_class(tag_size(bp));
        prv = heap_rd(bp);
        nxt = heap_rd(bp + 4);
        if (prv == MARK_BASE + 4 * c) list_head[c] = nxt & AMASK;
        else heap_wr(prv + 4, nxt);
        if (nxt != 0) heap_wr(nxt, prv);
    endfunction

    // join a free block with free neighbors, returns the surviving block
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned pf;
        int unsigned size;
        int unsigned nh;
        int unsigned pb;
        int unsigned nb;
        int unsigned ns;
        pf = heap_rd(bp - 8);
        size = tag_size(bp);
        nh = heap_rd(bp + size - 4);
        pb = bp - (pf & ~32'd7);
        nb = bp + size;
        if (pf[0] && nh[0]) return bp;
        if (pf[0]) begin
            list_drop(nb);
            list_drop(bp);
            size += tag_size(nb);
            heap_wr(bp - 4, size);
            heap_wr(bp + size - 8, size);
            list_push(bp);
            return bp;
        end
        if (nh[0]) begin
            list_drop(pb);
            list_drop(bp);
            heap_wr(bp + size - 8, size + tag_size(pb));
            size += tag_size(pb);
            heap_wr(pb - 4, size);
            list_push(pb);
            return pb;
        end
        list_drop(pb);
        list_drop(bp);
        list_drop(nb);
        ns = tag_size(nb);
        size += tag_size(pb) + ns;
        heap_wr(pb - 4, size);
        heap_wr(nb + ns - 8, size);
        list_push(pb);
        return pb;
    endfunction

    function automatic int unsigned heap_grow(int unsigned amount);
        longint unsigned sz;
        int unsigned bp;
        sz = (((longint'(amount) / 4) + 1) / 2) * 8;
        if (longint'(brk) + sz > longint'(HEAP_SIZE)) return 0;
        bp = brk;
        heap_wr(bp - 4, int'(sz));
        heap_wr(bp + int'(sz) - 8, int'(sz));
        heap_wr(bp + int'(sz) - 4, 1);
        brk = (bp + int'(sz)) & SMASK;
        list_push(bp);
        return coalesce(bp);
    endfunction

    function automatic int unsigned first_fit(int unsigned asize);
        int unsigned steps;
        int unsigned bp;
        steps = 0;
        for (int c = size_class(asize); c < 16; c++) begin
            bp = list_head[c];
            while (bp != 0) begin
                if (steps >= SEARCH_MAX) return 0;
                steps++;
                if (tag_size(bp) >= asize) return bp;
                bp = heap_rd(bp + 4) & AMASK;
            end
        end
        return 0;
    endfunction

    function automatic int unsigned split_block(int unsigned bp, int unsigned asize);
        int unsigned csize;
        int unsigned rest;
        csize = tag_size(bp);
        list_drop(bp);
        if (csize - asize >= 16) begin
            rest = bp + asize;
            heap_wr(bp - 4, asize | 1);
            heap_wr(bp + asize - 8, asize | 1);
            heap_wr(rest - 4, csize - asize);
            heap_wr(rest + csize - asize - 8, csize - asize);
            list_push(rest);
            return asize;
        end
        heap_wr(bp - 4, csize | 1);
        heap_wr(bp + csize - 8, csize | 1);
        return csize;
    endfunction

    function automatic void heap_reset();
        foreach (heap_img[i]) heap_img[i] = 0;
        foreach (list_head[i]) list_head[i] = 0;
        heap_wr(76, 9);
        heap_wr(80, 9);
        heap_wr(84, 4096);
        heap_wr(4176, 4096);
        heap_wr(4180, 1);
        heap_wr(88, MARK_BASE + 4 * 12);
        heap_wr(92, 0);
        list_head[12] = 88;
        brk = 4184;
        chunk = 4096;
    endfunction

    // expected grant of one request, updates predictor state
    function automatic grant_t predict_request(logic kind, int unsigned req, int unsigned baddr);
        grant_t g;
        int unsigned asize;
        int unsigned bp;
        int unsigned c;
        int unsigned ext;
        int unsigned hdr;
        int unsigned sz;
        g.addr = 0;
        g.nul = 1'b1;
        g.bytes = 0;
        if (kind == shal_pkg::KIND_ALLOC) begin
            if (req == 0) return g;
            asize = (req <= 8) ? 16 : 8 * ((req + 15) / 8);
            bp = first_fit(asize);
            if (bp == 0) begin
                c = size_class(asize);
                if (c == 15) ext = asize;
                else ext = (BOUND[c] > chunk) ? BOUND[c] : chunk;
                bp = heap_grow(ext);
                if (bp == 0) return g;
            end
            g.bytes = split_block(bp, asize) & SMASK;
            g.addr = bp & AMASK;
            g.nul = 1'b0;
            return g;
        end
        bp = baddr;
        if (bp == 0 || (bp & 7) != 0 || bp < 88 || bp >= brk) return g;
        hdr = heap_rd(bp - 4);
        sz = hdr & ~32'd7;
        if (hdr[0] == 1'b0 || sz < 16) return g;
        if (longint'(bp) + sz > longint'(brk)) return g;
        if (heap_rd(bp + sz - 8) != hdr) return g;
        heap_wr(bp - 4, sz);
        heap_wr(bp + sz - 8, sz);
        list_push(bp);
        void'(coalesce(bp));
        return g;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[19:0], 0);
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata[19:0] != want.addr) report_mismatch("granted_addr", m_tdata[19:0], want.addr);
                if (m_tuser[0] != want.nul) report_mismatch("is_null", m_tuser[0], want.nul);
                if (m_tdata[40:20] != want.bytes) report_mismatch("granted_bytes", m_tdata[40:20], want.bytes);
                if (m_tdata[47:41] != 0) report_mismatch("tdata padding", m_tdata[47:41], 0);
            end
        end
    end

    // send one request item; starts and ends at a falling edge
    task automatic send_request(logic kind, int unsigned req, int unsigned baddr);
        grant_t g;
        int unsigned i;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, baddr[19:0], req[20:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        g = predict_request(kind, req, baddr);
        pending_grants.push_back(g);
        if (kind == shal_pkg::KIND_ALLOC && !g.nul) live_blocks.push_back(g.addr);
        if (kind == shal_pkg::KIND_FREE) begin
            for (i = 0; i < live_blocks.size(); i++) begin
                if (live_blocks[i] == baddr) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        @(negedge aclk);
    endtask

    // hold off until every expected item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_grants.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_chunk(int unsigned value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value[20:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        chunk = value & SMASK;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // zero size, tiny sizes, class edges, heap full, and the free corner cases
    task automatic test_directed();
        int unsigned a;
        int unsigned b;
        send_request(shal_pkg::KIND_ALLOC, 0, 0);
        send_request(shal_pkg::KIND_ALLOC, 1, 0);
        send_request(shal_pkg::KIND_ALLOC, 8, 0);
        send_request(shal_pkg::KIND_ALLOC, 9, 0);
        a = live_blocks[live_blocks.size() - 1];
        send_request(shal_pkg::KIND_ALLOC, 100, 0);
        b = live_blocks[live_blocks.size() - 1];
        send_request(shal_pkg::KIND_ALLOC, 5000, 0);
        send_request(shal_pkg::KIND_ALLOC, 30000, 0);
        send_request(shal_pkg::KIND_ALLOC, 1048576, 0);
        send_request(shal_pkg::KIND_ALLOC, 21'h1F_FFFF, 0);
        send_request(shal_pkg::KIND_FREE, 0, 0);
        send_request(shal_pkg::KIND_FREE, 0, 4);
        send_request(shal_pkg::KIND_FREE, 0, 80);
        send_request(shal_pkg::KIND_FREE, 0, 20'hF_FFF8);
        send_request(shal_pkg::KIND_FREE, 21'h1F_FFFF, a);
        send_request(shal_pkg::KIND_FREE, 0, a);
        send_request(shal_pkg::KIND_FREE, 0, b);
        send_request(shal_pkg::KIND_FREE, 0, a + 8);
        while (live_blocks.size() != 0) send_request(shal_pkg::KIND_FREE, 0, live_blocks[0]);
    endtask

    // smallest and largest growth amounts
    task automatic test_chunk_extremes();
        write_chunk(8);
        send_request(shal_pkg::KIND_ALLOC, 2000, 0);
        send_request(shal_pkg::KIND_ALLOC, 40000, 0);
        write_chunk(1048576);
        send_request(shal_pkg::KIND_ALLOC, 60000, 0);
        send_request(shal_pkg::KIND_ALLOC, 100000, 0);
        while (live_blocks.size() != 0) send_request(shal_pkg::KIND_FREE, 0, live_blocks[0]);
        write_chunk(4096);
    endtask

    function automatic int unsigned random_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(1, 128);
        if (r < 85) return $urandom_range(129, 3000);
        if (r < 95) return $urandom_range(3001, 30000);
        if (r < 98) return $urandom_range(0, 8);
        return $urandom_range(0, 21'h1F_FFFF);
    endfunction

    // mostly well-formed alloc and free traffic, some garbage frees
    task automatic test_random(int unsigned count, int unsigned src_pct, int unsigned snk_pct);
        int unsigned r;
        int unsigned idx;
        send_idle_pct = src_pct;
        recv_idle_pct = snk_pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (n == count / 2) drain();
            if (r < 5) begin
                send_request(shal_pkg::KIND_FREE, $urandom_range(0, 21'h1F_FFFF),
                             $urandom_range(0, 20'hF_FFFF));
            end else if (live_blocks.size() != 0 &&
                         r < ((live_blocks.size() > 80) ? 70 : 45)) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                send_request(shal_pkg::KIND_FREE, $urandom_range(0, 21'h1F_FFFF),
                             live_blocks[idx]);
            end else begin
                send_request(shal_pkg::KIND_ALLOC, random_size(), $urandom_range(0, 20'hF_FFFF));
            end
        end
    endtask

    initial begin
        heap_reset();
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 17;
        recv_idle_pct = 75;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_chunk_extremes();
        test_random(300, 17, 75);
        write_chunk($urandom_range(8, 512));
        test_random(300, 75, 17);
        write_chunk($urandom_range(8192, 65536));
        test_random(300, 0, 0);

        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
